>>> hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared types, character codes, result kinds and result-building helpers.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int DEF_MAX_TOKENS  = 16;
    localparam int DEF_TOKEN_BYTES = 256;

    // Most results one input byte can cause.
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef enum logic [2:0] {
        M_BETWEEN,
        M_BARE,
        M_QUOTED,
        M_ESCAPE,
        M_CUTQ
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] token_index;
        logic [7:0] position;
        logic [7:0] out_byte;
        logic [4:0] token_count;
    } t_result;

    // All results caused by one input byte, in order, with their number.
    typedef struct packed {
        logic [1:0]                    n;
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

    function automatic t_result f_res(logic [1:0] kind, logic [3:0] idx,
                                      logic [7:0] pos, logic [7:0] byte_val,
                                      logic [4:0] cnt);
        t_result r;
        r.kind        = kind;
        r.token_index = idx;
        r.position    = pos;
        r.out_byte    = byte_val;
        r.token_count = cnt;
        return r;
    endfunction

    function automatic t_bundle f_push(t_bundle b, t_result r);
        t_bundle o;
        o            = b;
        o.res[b.n]   = r;
        o.n          = b.n + 2'd1;
        return o;
    endfunction

endpackage

>>> hw/rtl/clt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer input channel
// Valid/ready channel that carries one input byte per item.
// ----------------------------------------------------------------------------
interface clt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_value;

    modport source (output valid, output char_value, input ready);
    modport sink   (input valid, input char_value, output ready);
endinterface

>>> hw/rtl/clt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer result channel
// Valid/ready channel that carries one token byte, token end or line done.
// ----------------------------------------------------------------------------
interface clt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] token_index;
    logic [7:0] position;
    logic [7:0] out_byte;
    logic [4:0] token_count;
    logic       last;

    modport source (output valid, output kind, output token_index, output position,
                    output out_byte, output token_count, output last, input ready);
    modport sink   (input valid, input kind, input token_index, input position,
                    input out_byte, input token_count, input last, output ready);
endinterface

>>> hw/rtl/clt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Next mode, token count and byte position plus the results for one byte.
// ----------------------------------------------------------------------------
module clt_step
    import clt_pkg::*;
#(
    parameter int MAX_TOKENS  = DEF_MAX_TOKENS,
    parameter int TOKEN_BYTES = DEF_TOKEN_BYTES,
    parameter int CNT_W       = $clog2(MAX_TOKENS + 1),
    parameter int CP_W        = $clog2(TOKEN_BYTES)
) (
    input  logic [7:0]      i_byte,
    input  t_mode           i_mode,
    input  logic [CNT_W-1:0] i_count,
    input  logic [CP_W-1:0]  i_cpos,
    output t_mode           o_mode,
    output logic [CNT_W-1:0] o_count,
    output logic [CP_W-1:0]  o_cpos,
    output t_bundle         o_bundle
);

    t_bundle          b;
    t_mode            md;
    t_mode            st_mode;
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
    logic [CP_W:0]    cp_inc;
    logic             do_store;
    logic [7:0]       st_byte;

    always_comb begin
        b        = '0;
        md       = i_mode;
        cnt      = i_count;
        cp       = i_cpos;
        cp_inc   = '0;
        do_store = 1'b0;
        st_byte  = i_byte;
        st_mode  = M_BETWEEN;

        if (i_byte == CH_NUL) begin
            unique case (i_mode) inside
                M_ESCAPE: begin
                    // A dangling backslash is kept as a plain token byte.
                    cp_inc = {1'b0, cp} + (CP_W+1)'(1);
                    b   = f_push(b, f_res(KIND_BYTE, 4'(cnt), 8'(cp), CH_BSLASH, 5'd0));
                    b   = f_push(b, f_res(KIND_END, 4'(cnt), 8'(cp_inc), 8'd0, 5'd0));
                    cnt = cnt + CNT_W'(1);
                end
                M_BARE, M_QUOTED: begin
                    b   = f_push(b, f_res(KIND_END, 4'(cnt), 8'(cp), 8'd0, 5'd0));
                    cnt = cnt + CNT_W'(1);
                end
                default: begin
                end
            endcase
            b   = f_push(b, f_res(KIND_DONE, 4'd0, 8'd0, 8'd0, 5'(cnt)));
            md  = M_BETWEEN;
            cnt = '0;
            cp  = '0;
        end else begin
            unique case (i_mode) inside
                M_BARE: begin
                    if (i_byte == CH_SPACE) begin
                        b   = f_push(b, f_res(KIND_END, 4'(cnt), 8'(cp), 8'd0, 5'd0));
                        cnt = cnt + CNT_W'(1);
                        cp  = '0;
                        md  = M_BETWEEN;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                M_QUOTED: begin
                    if (i_byte == CH_QUOTE) begin
                        b   = f_push(b, f_res(KIND_END, 4'(cnt), 8'(cp), 8'd0, 5'd0));
                        cnt = cnt + CNT_W'(1);
                        cp  = '0;
                        md  = M_BETWEEN;
                    end else if (i_byte == CH_BSLASH) begin
                        md = M_ESCAPE;
                    end else begin
                        do_store = 1'b1;
                        st_mode  = M_CUTQ;
                    end
                end
                M_ESCAPE: begin
                    md       = M_QUOTED;
                    do_store = 1'b1;
                    st_mode  = M_CUTQ;
                    st_byte  = (i_byte == CH_N) ? CH_LF : i_byte;
                end
                default: begin
                    md = M_BETWEEN;
                    // The quote right after a cut quoted token is swallowed.
                    if (!(i_mode == M_CUTQ && i_byte == CH_QUOTE) &&
                        cnt < CNT_W'(MAX_TOKENS) && i_byte != CH_SPACE) begin
                        cp = '0;
                        if (i_byte == CH_QUOTE) begin
                            md = M_QUOTED;
                        end else begin
                            md       = M_BARE;
                            do_store = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (do_store) begin
            b      = f_push(b, f_res(KIND_BYTE, 4'(cnt), 8'(cp), st_byte, 5'd0));
            cp_inc = {1'b0, cp} + (CP_W+1)'(1);
            // A full token is closed and the following bytes open a new one.
            if (cp_inc >= (CP_W+1)'(TOKEN_BYTES - 1)) begin
                b   = f_push(b, f_res(KIND_END, 4'(cnt), 8'(cp_inc), 8'd0, 5'd0));
                cnt = cnt + CNT_W'(1);
                cp  = '0;
                md  = st_mode;
            end else begin
                cp = cp_inc[CP_W-1:0];
            end
        end

        o_mode   = md;
        o_count  = cnt;
        o_cpos   = cp;
        o_bundle = b;
    end

endmodule

>>> hw/rtl/clt_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer result emitter
// Holds the results of one byte and hands them out one item per handshake.
// ----------------------------------------------------------------------------
module clt_emit
    import clt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_bundle     i_bundle,
    output logic        o_free,
    clt_out_if.source   o_res_ch
);

    logic        r_valid;
    t_bundle     r_bundle;
    logic [1:0]  r_idx;
    logic        pop;
    logic        last_res;
    t_result     cur;

    assign cur      = r_bundle.res[r_idx];
    assign last_res = (r_idx == r_bundle.n - 2'd1);
    assign pop      = r_valid && o_res_ch.ready;
    assign o_free   = !r_valid || (pop && last_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_load && i_bundle.n != 2'd0) begin
                r_valid  <= 1'b1;
                r_bundle <= i_bundle;
                r_idx    <= '0;
            end else if (pop) begin
                if (last_res) begin
                    r_valid <= 1'b0;
                end
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_res_ch.valid       = r_valid;
    assign o_res_ch.kind        = cur.kind;
    assign o_res_ch.token_index = cur.token_index;
    assign o_res_ch.position    = cur.position;
    assign o_res_ch.out_byte    = cur.out_byte;
    assign o_res_ch.token_count = cur.token_count;
    assign o_res_ch.last        = last_res;

endmodule

>>> hw/rtl/command_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a byte stream into bare and quoted tokens, one byte per item.
// ----------------------------------------------------------------------------
//  Channel    Dir  Payload                                         Handshake
//  i_char_ch  in   char_value                                      valid/ready
//  o_tok_ch   out  kind, token_index, position, out_byte,          valid/ready
//                  token_count, last
//
//  An accepted byte is latched in the input register, then decoded
//  combinationally into up to three results that are loaded into an output
//  register once it is free; the first result is then offered on o_tok_ch.
//  Throughput is one byte per cycle while each byte gives at most one result
//  and o_tok_ch is ready; a byte with more results holds the output register
//  until the last is taken. Reset clears the mode, token count and position.
//  A stalled result channel backs up into the input register and then i_char_ch.
// ----------------------------------------------------------------------------
module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int MAX_TOKENS  = DEF_MAX_TOKENS,
    parameter int TOKEN_BYTES = DEF_TOKEN_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clt_in_if.sink     i_char_ch,
    clt_out_if.source  o_tok_ch
);

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int CP_W  = $clog2(TOKEN_BYTES);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    t_mode            r_mode;
    logic [CNT_W-1:0] r_count;
    logic [CP_W-1:0]  r_cpos;

    t_mode            n_mode;
    logic [CNT_W-1:0] n_count;
    logic [CP_W-1:0]  n_cpos;
    t_bundle          step_bundle;
    logic             emit_free;
    logic             proc;

    assign proc            = r_in_valid && emit_free;
    assign i_char_ch.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_BETWEEN;
            r_count    <= '0;
            r_cpos     <= '0;
        end else begin
            if (i_char_ch.valid && i_char_ch.ready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_char_ch.char_value;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_cpos  <= n_cpos;
            end
        end
    end

    clt_step #(
        .MAX_TOKENS  (MAX_TOKENS),
        .TOKEN_BYTES (TOKEN_BYTES),
        .CNT_W       (CNT_W),
        .CP_W        (CP_W)
    ) u_step (
        .i_byte   (r_in_byte),
        .i_mode   (r_mode),
        .i_count  (r_count),
        .i_cpos   (r_cpos),
        .o_mode   (n_mode),
        .o_count  (n_count),
        .o_cpos   (n_cpos),
        .o_bundle (step_bundle)
    );

    clt_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (proc),
        .i_bundle (step_bundle),
        .o_free   (emit_free),
        .o_res_ch (o_tok_ch)
    );

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TOKENS))
        else $error("token count above limit");

    a_cpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cpos} < (CP_W+1)'(TOKEN_BYTES - 1))
        else $error("open token longer than the cut length");

    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_byte == CH_NUL |=> r_mode == M_BETWEEN && r_count == '0 &&
        r_cpos == '0)
        else $error("line end did not clear the tokenizer state");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_ch.valid && o_tok_ch.kind == KIND_DONE |-> o_tok_ch.last)
        else $error("line done is not the final result of its item");
`endif

endmodule

>>> tb/command_line_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Drives byte streams into the tokenizer and checks each token byte, token
// end and line done against a predictor of its own. Covers directed corner
// cases, a quoted token cut, the token limit and random lines, most under random
// idling on both channels.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;
    import clt_pkg::*;

    localparam int TOK_LIMIT   = DEF_MAX_TOKENS;
    localparam int TOK_BYTES   = DEF_TOKEN_BYTES;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 200;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_token_exp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    clt_in_if  char_ch ();
    clt_out_if tok_ch ();

    command_line_tokenizer #(
        .MAX_TOKENS  (TOK_LIMIT),
        .TOKEN_BYTES (TOK_BYTES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char_ch (char_ch),
        .o_tok_ch  (tok_ch)
    );

    always #5 i_clk = ~i_clk;

    // Tokenizer state as tracked by the predictor.
    t_mode tk_mode;
    int    tk_count;
    int    tk_pos;

    t_token_exp step_out[$];
    t_token_exp results_due[$];
    logic [7:0] char_pending[$];

    int  chars_queued;
    int  mismatches;
    int  results_seen;
    int  cycle_count;
    bit  char_taken;
    bit  gaps_on;
    bit  long_hold_req;
    int  send_gap;
    int  hold_left;
    int  stall_left;

    function automatic void emit(logic [1:0] kind, int idx, int pos, logic [7:0] b,
                                 int cnt);
        t_token_exp e;
        e.res.kind        = kind;
        e.res.token_index = idx[3:0];
        e.res.position    = pos[7:0];
        e.res.out_byte    = b;
        e.res.token_count = cnt[4:0];
        e.last            = 1'b0;
        step_out.push_back(e);
    endfunction

    function automatic void close_token();
        emit(KIND_END, tk_count, tk_pos, 8'd0, 0);
        tk_count++;
        tk_pos = 0;
    endfunction

    // Store one byte; a full token is ended and the mode moves on.
    function automatic void keep_byte(logic [7:0] b, t_mode after_cut);
        emit(KIND_BYTE, tk_count, tk_pos, b, 0);
        tk_pos++;
        if (tk_pos >= TOK_BYTES - 1) begin
            close_token();
            tk_mode = after_cut;
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] c);
        step_out.delete();
        if (c == CH_NUL) begin
            if (tk_mode == M_ESCAPE) begin
                emit(KIND_BYTE, tk_count, tk_pos, CH_BSLASH, 0);
                tk_pos++;
                close_token();
            end else if (tk_mode == M_BARE || tk_mode == M_QUOTED) begin
                close_token();
            end
            emit(KIND_DONE, 0, 0, 8'd0, tk_count);
            tk_mode  = M_BETWEEN;
            tk_count = 0;
            tk_pos   = 0;
        end else begin
            case (tk_mode)
                M_BARE: begin
                    if (c == CH_SPACE) begin
                        close_token();
                        tk_mode = M_BETWEEN;
                    end else begin
                        keep_byte(c, M_BETWEEN);
                    end
                end
                M_QUOTED: begin
                    if (c == CH_QUOTE) begin
                        close_token();
                        tk_mode = M_BETWEEN;
                    end else if (c == CH_BSLASH) begin
                        tk_mode = M_ESCAPE;
                    end else begin
                        keep_byte(c, M_CUTQ);
                    end
                end
                M_ESCAPE: begin
                    tk_mode = M_QUOTED;
                    keep_byte((c == CH_N) ? CH_LF : c, M_CUTQ);
                end
                default: begin
                    // A quote right after a cut quoted token is swallowed.
                    if (tk_mode == M_CUTQ && c == CH_QUOTE) begin
                        tk_mode = M_BETWEEN;
                    end else begin
                        tk_mode = M_BETWEEN;
                        if (tk_count < TOK_LIMIT && c != CH_SPACE) begin
                            tk_pos = 0;
                            if (c == CH_QUOTE) begin
                                tk_mode = M_QUOTED;
                            end else begin
                                tk_mode = M_BARE;
                                keep_byte(c, M_BETWEEN);
                            end
                        end
                    end
                end
            endcase
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[k])
            results_due.push_back(step_out[k]);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
    endtask

    function automatic void put_char(logic [7:0] c);
        char_pending.push_back(c);
        chars_queued++;
    endfunction

    function automatic logic [7:0] bare_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE);
        return c;
    endfunction

    // One stored byte of a quoted token: a plain byte or an escape pair.
    function automatic void queue_quoted_unit();
        logic [7:0] c;
        if ($urandom_range(0, 5) == 0) begin
            put_char(CH_BSLASH);
            case ($urandom_range(0, 3))
                0: put_char(CH_N);
                1: put_char(CH_QUOTE);
                2: put_char(CH_BSLASH);
                default: put_char(8'($urandom_range(1, 255)));
            endcase
        end else begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == CH_QUOTE || c == CH_BSLASH);
            put_char(c);
        end
    endfunction

    function automatic void queue_long_quoted(int units, logic [7:0] tail);
        put_char(CH_QUOTE);
        repeat (units) queue_quoted_unit();
        put_char(tail);
        put_char("a");
        put_char(CH_NUL);
    endfunction

    function automatic void queue_line();
        int  style;
        int  ntok;
        int  len;
        int  t;
        bit  open_q;
        bit  prev_bare;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            // Noise: any bytes, line ends wherever a zero falls.
            len = $urandom_range(1, 12);
            repeat (len) put_char(8'($urandom_range(0, 255)));
            put_char(CH_NUL);
            return;
        end
        ntok      = (style == 1) ? $urandom_range(15, 20) : $urandom_range(1, 5);
        open_q    = 1'b0;
        prev_bare = 1'b0;
        for (t = 0; t < ntok && !open_q; t++) begin
            repeat ($urandom_range(prev_bare ? 1 : 0, 2)) put_char(CH_SPACE);
            if ($urandom_range(0, 1) == 1) begin
                len = $urandom_range(1, 6);
                repeat (len) put_char(bare_char());
                prev_bare = 1'b1;
            end else begin
                put_char(CH_QUOTE);
                len = $urandom_range(0, 5);
                repeat (len) queue_quoted_unit();
                case ($urandom_range(0, 11))
                    0: open_q = 1'b1;
                    1: begin
                        put_char(CH_BSLASH);
                        open_q = 1'b1;
                    end
                    default: put_char(CH_QUOTE);
                endcase
                prev_bare = 1'b0;
            end
        end
        if (!open_q)
            repeat ($urandom_range(0, 2)) put_char(CH_SPACE);
        put_char(CH_NUL);
    endfunction

    task automatic drain();
        while (char_pending.size() != 0 || char_ch.valid || results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Byte driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_ch.valid <= 1'b0;
        end else if (!char_ch.valid || char_taken) begin
            char_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                char_ch.valid <= 1'b0;
            end else if (char_pending.size() == 0) begin
                char_ch.valid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 19) - 1;
                char_ch.valid <= 1'b0;
            end else begin
                char_ch.valid      <= 1'b1;
                char_ch.char_value <= char_pending.pop_front();
            end
        end
    end

    // Result channel back-pressure.
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            tok_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            tok_ch.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            tok_ch.ready <= 1'b0;
        end else begin
            tok_ch.ready <= 1'b1;
        end
    end

    // Results are checked before the byte of the same edge is predicted.
    always @(posedge i_clk) begin : monitor
        t_token_exp want;
        if (i_rst_n) begin
            if (tok_ch.valid && tok_ch.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing pending, kind",
                                    int'(tok_ch.kind), -1);
                end else begin
                    want = results_due.pop_front();
                    if (tok_ch.kind !== want.res.kind)
                        report_mismatch("kind", int'(tok_ch.kind), int'(want.res.kind));
                    if (tok_ch.token_index !== want.res.token_index)
                        report_mismatch("token_index", int'(tok_ch.token_index),
                                        int'(want.res.token_index));
                    if (tok_ch.position !== want.res.position)
                        report_mismatch("position", int'(tok_ch.position),
                                        int'(want.res.position));
                    if (tok_ch.out_byte !== want.res.out_byte)
                        report_mismatch("out_byte", int'(tok_ch.out_byte),
                                        int'(want.res.out_byte));
                    if (tok_ch.token_count !== want.res.token_count)
                        report_mismatch("token_count", int'(tok_ch.token_count),
                                        int'(want.res.token_count));
                    if (tok_ch.last !== want.last)
                        report_mismatch("last", int'(tok_ch.last), int'(want.last));
                end
                results_seen++;
            end
            if (char_ch.valid && char_ch.ready) begin
                tokenize_byte(char_ch.char_value);
                char_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [7:0] intro [];
        int         random_start;
        tk_mode            = M_BETWEEN;
        tk_count           = 0;
        tk_pos             = 0;
        chars_queued       = 0;
        mismatches         = 0;
        results_seen       = 0;
        cycle_count        = 0;
        char_taken         = 1'b0;
        gaps_on            = 1'b1;
        long_hold_req      = 1'b0;
        send_gap           = 0;
        hold_left          = 0;
        stall_left         = 0;
        i_rst_n            = 1'b0;
        char_ch.valid      = 1'b0;
        char_ch.char_value = 8'd0;
        tok_ch.ready       = 1'b0;

        // Empty line; byte extremes; empty quotes followed at once by text with a
        // quote inside a bare token; escapes; unclosed quotes, one ending in a
        // backslash.
        intro = '{CH_NUL, 8'hFF, 8'h01, CH_SPACE, CH_QUOTE, CH_QUOTE, "x", CH_QUOTE, "y",
                  CH_SPACE, CH_QUOTE, CH_BSLASH, CH_N, CH_BSLASH, CH_QUOTE, "q", CH_QUOTE,
                  CH_QUOTE, "z", CH_BSLASH, CH_NUL, CH_QUOTE, "k", CH_NUL};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (intro[k])
            put_char(intro[k]);

        // Token limit: more empty quoted tokens than fit, then a stray byte.
        repeat (TOK_LIMIT + 1) begin
            put_char(CH_QUOTE);
            put_char(CH_QUOTE);
        end
        put_char("x");
        put_char(CH_NUL);
        drain();

        // Token cut inside a quoted token, with the receiver held off so that
        // the block backs up; the quote right after the cut is swallowed.
        long_hold_req = 1'b1;
        queue_long_quoted(TOK_BYTES - 1, CH_QUOTE);

        random_start = chars_queued;
        while (chars_queued - random_start < 40)
            queue_line();
        drain();
        while (chars_queued - random_start < 80)
            queue_line();

        while (char_pending.size() != 0)
            @(posedge i_clk);
        gaps_on = 1'b0;
        while (chars_queued - random_start < 110)
            queue_line();

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/clt_pkg.sv
hw/rtl/clt_in_if.sv
hw/rtl/clt_out_if.sv
hw/rtl/clt_step.sv
hw/rtl/clt_emit.sv
hw/rtl/command_line_tokenizer.sv
tb/command_line_tokenizer_tb.sv
